>>> sv/brf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and codes for the byte ring FIFO with DMA pointer sync.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEPTH_DEF   = 256;
  localparam int SIZE_LOG2_W = 4;

  localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RST = 4'd8;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_PEEK   = 3'd2;
  localparam logic [2:0] ACT_SKIP   = 3'd3;
  localparam logic [2:0] ACT_COMMIT = 3'd4;
  localparam logic [2:0] ACT_DMA    = 3'd5;
  localparam logic [2:0] ACT_CLEAR  = 3'd6;

  localparam logic [2:0] LVL_EMPTY        = 3'd0;
  localparam logic [2:0] LVL_ALMOST_EMPTY = 3'd1;
  localparam logic [2:0] LVL_HALF         = 3'd2;
  localparam logic [2:0] LVL_PARTIAL      = 3'd3;
  localparam logic [2:0] LVL_ALMOST_FULL  = 3'd4;
  localparam logic [2:0] LVL_FULL         = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
    logic [8:0] amount;
    logic [7:0] peek_offset;
    logic [7:0] dma_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [8:0] done_count;
    logic [8:0] fill_level;
    logic [8:0] free_space;
    logic [2:0] level_state;
    logic       overrun;
  } out_item_t;

endpackage
`default_nettype wire

>>> sv/byte_ring_fifo_with_dma_sync_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_dma_sync_core
// Byte ring FIFO with push, pop, peek, skip, commit and DMA pointer sync.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carries one action per transfer; every action
//   gives exactly one result on out_valid/out_ready/out_data, in order.
//   cfg_valid/cfg_ready/cfg_data writes size_log2 (clamped to 1..log2 DEPTH)
//   and empties the FIFO; write it only while no result is outstanding.
//   Stages: the middle stage loads at the input transfer (pointer update
//   and store access), and the result register loads from the middle
//   stage. Throughput: one action per cycle while in_ready is high, set
//   by the pointer update that each action hands to the next.
//   Stalls: with out_ready low one result waits in the output register and
//   one more in the middle stage; in_ready drops only when both are full.
//   Reset: both pointers clear, size_log2 returns to 8, no result is
//   pending. Store contents are undefined until written.
//   DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_dma_sync_core #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  brf_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output brf_pkg::out_item_t                  out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [brf_pkg::SIZE_LOG2_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > 9) ? PW + 1 : 10;
  localparam logic [4:0] AW_L = 5'(AW);

  typedef struct packed {
    brf_pkg::out_item_t res;
    logic               rd;
  } mid_t;

  logic [7:0]                      mem [0:DEPTH-1];
  logic [7:0]                      mem_q_r;
  logic [PW-1:0]                   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [brf_pkg::SIZE_LOG2_W-1:0] size_log2_r;
  logic [4:0]                      lg;
  logic [PW-1:0]                   size, amask, fill, space, fill_nxt;
  logic [PW-1:0]                   idx, cur, move, wp_dma, fill_dma, peek_sum, done;
  logic [AW-1:0]                   waddr, raddr;
  logic                            we, rd_hit, ovr;
  logic                            in_acc, s1_move;
  logic                            s1_valid_r, out_valid_r;
  mid_t                            s1_r, s1_nxt;
  brf_pkg::out_item_t              out_r, out_nxt;

  function automatic logic [2:0] level_of(input logic [PW-1:0] len,
                                          input logic [PW-1:0] sz);
    logic [2:0] lvl;
    if (len == '0) begin
      lvl = brf_pkg::LVL_EMPTY;
    end else if (len == sz) begin
      lvl = brf_pkg::LVL_FULL;
    end else if (len >= sz - (sz >> 2)) begin
      lvl = brf_pkg::LVL_ALMOST_FULL;
    end else if (len >= (sz >> 1) - (sz >> 3) && len <= (sz >> 1) + (sz >> 3)) begin
      lvl = brf_pkg::LVL_HALF;
    end else if (len <= (sz >> 2)) begin
      lvl = brf_pkg::LVL_ALMOST_EMPTY;
    end else begin
      lvl = brf_pkg::LVL_PARTIAL;
    end
    return lvl;
  endfunction

  always_comb begin
    if (size_log2_r == '0) begin
      lg = 5'd1;
    end else if (5'(size_log2_r) > AW_L) begin
      lg = AW_L;
    end else begin
      lg = 5'(size_log2_r);
    end
  end

  assign size  = PW'(1) << lg;
  assign amask = size - PW'(1);
  assign fill  = wp_r - rp_r;
  assign space = size - fill;

  assign idx      = PW'(in_data.dma_index) & amask;
  assign cur      = wp_r & amask;
  assign move     = (idx >= cur) ? idx - cur : idx + size - cur;
  assign wp_dma   = wp_r + move;
  assign fill_dma = wp_dma - rp_r;
  assign peek_sum = rp_r + PW'(in_data.peek_offset);

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    done   = '0;
    we     = 1'b0;
    rd_hit = 1'b0;
    ovr    = 1'b0;
    waddr  = wp_r[AW-1:0] & amask[AW-1:0];
    raddr  = rp_r[AW-1:0] & amask[AW-1:0];
    case (in_data.action)
      brf_pkg::ACT_PUSH: begin
        if (fill != size) begin
          we     = 1'b1;
          wp_nxt = wp_r + PW'(1);
          done   = PW'(1);
        end
      end
      brf_pkg::ACT_POP: begin
        if (fill != '0) begin
          rd_hit = 1'b1;
          rp_nxt = rp_r + PW'(1);
          done   = PW'(1);
        end
      end
      brf_pkg::ACT_PEEK: begin
        if (CW'(in_data.peek_offset) < CW'(fill)) begin
          rd_hit = 1'b1;
          raddr  = peek_sum[AW-1:0] & amask[AW-1:0];
          done   = PW'(1);
        end
      end
      brf_pkg::ACT_SKIP: begin
        done   = (CW'(in_data.amount) < CW'(fill)) ? PW'(in_data.amount) : fill;
        rp_nxt = rp_r + done;
      end
      brf_pkg::ACT_COMMIT: begin
        done   = (CW'(in_data.amount) < CW'(space)) ? PW'(in_data.amount) : space;
        wp_nxt = wp_r + done;
      end
      brf_pkg::ACT_DMA: begin
        done = move;
        if (move != '0) begin
          wp_nxt = wp_dma;
          if (fill_dma > size) begin
            rp_nxt = wp_dma - size;
            ovr    = 1'b1;
          end
        end
      end
      brf_pkg::ACT_CLEAR: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      default: begin
      end
    endcase
    fill_nxt = wp_nxt - rp_nxt;

    s1_nxt.rd                 = rd_hit;
    s1_nxt.res.read_data      = '0;
    s1_nxt.res.done_count     = 9'(done);
    s1_nxt.res.fill_level     = 9'(fill_nxt);
    s1_nxt.res.free_space     = 9'(size - fill_nxt);
    s1_nxt.res.level_state    = level_of(fill_nxt, size);
    s1_nxt.res.overrun        = ovr;
  end

  always_comb begin
    out_nxt           = s1_r.res;
    out_nxt.read_data = s1_r.rd ? mem_q_r : 8'd0;
  end

  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (in_acc && we) begin
      mem[waddr] <= in_data.data;
    end
    if (in_acc && rd_hit) begin
      mem_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      size_log2_r <= brf_pkg::SIZE_LOG2_RST;
    end else if (cfg_valid) begin
      wp_r        <= '0;
      rp_r        <= '0;
      size_log2_r <= cfg_data;
    end else if (in_acc) begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_r <= out_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= size)
    else $error("fill level exceeds size in use");

  a_mid_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_valid_r) |-> s1_move)
    else $error("middle stage overwritten");

  a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overrun) |-> (out_r.free_space == 9'd0))
    else $error("overrun without full FIFO");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.level_state == brf_pkg::LVL_EMPTY) |->
      (out_r.fill_level == 9'd0))
    else $error("empty state with stored bytes");

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring FIFO with DMA pointer sync. A fixed
// table of actions at reset size runs first, then random actions over a
// series of buffer sizes. A behavioural model or a pinned table entry
// predicts each status transfer; the receiver compares it field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int BUILT_LOG2      = $clog2(brf_pkg::DEPTH_DEF);
  localparam int PTR_W           = BUILT_LOG2 + 1;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int N_PHASES        = 12;
  localparam int HOLD_PHASE      = 9;
  localparam int HOLD_CYCLES     = 200;
  localparam int WD_LIMIT        = 2000;
  localparam int DRAIN_CYCLES    = 10;

  localparam logic [2:0] ACT_UNUSED = 3'd7;

  localparam brf_pkg::out_item_t NO_STATUS = '0;

  typedef struct packed {
    brf_pkg::in_item_t  item;
    logic               pinned;
    brf_pkg::out_item_t status;
  } dir_row_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  brf_pkg::in_item_t               in_data   = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [brf_pkg::SIZE_LOG2_W-1:0] cfg_data  = '0;
  wire                             in_ready;
  wire                             out_valid;
  wire                             cfg_ready;
  brf_pkg::out_item_t              out_data;

  // model state
  logic [PTR_W-1:0]                wr_ptr = '0;
  logic [PTR_W-1:0]                rd_ptr = '0;
  logic [brf_pkg::SIZE_LOG2_W-1:0] size_lg = brf_pkg::SIZE_LOG2_RST;
  logic [7:0]                      ring_mem [brf_pkg::DEPTH_DEF];
  bit                              ring_written [brf_pkg::DEPTH_DEF];

  brf_pkg::out_item_t              ring_status_q [$];
  dir_row_t                        dir_tab [$];
  logic [brf_pkg::SIZE_LOG2_W-1:0] size_plan [N_PHASES] =
    '{4'd1, 4'd2, 4'd0, 4'd3, 4'd15, 4'd4, 4'd8, 4'd5, 4'd6, 4'd7, 4'd2, 4'd8};
  int        err_cnt     = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        stall_cycles = 0;
  bit        hold_req    = 1'b0;
  bit        fill_bias   = 1'b0;

  byte_ring_fifo_with_dma_sync_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned use_size();
    int unsigned lg;
    lg = size_lg;
    if (lg < 1) lg = 1;
    if (lg > BUILT_LOG2) lg = BUILT_LOG2;
    return 1 << lg;
  endfunction

  function automatic int unsigned cur_fill();
    logic [PTR_W-1:0] d;
    d = wr_ptr - rd_ptr;
    return d;
  endfunction

  function automatic logic [BUILT_LOG2-1:0] ring_addr(int unsigned off);
    return BUILT_LOG2'((rd_ptr + off) & (use_size() - 1));
  endfunction

  function automatic logic [2:0] level_of_fill(int unsigned n, int unsigned sz);
    if (n == 0) return brf_pkg::LVL_EMPTY;
    if (n == sz) return brf_pkg::LVL_FULL;
    if (n >= sz - sz / 4) return brf_pkg::LVL_ALMOST_FULL;
    if (n >= sz / 2 - sz / 8 && n <= sz / 2 + sz / 8) return brf_pkg::LVL_HALF;
    if (n <= sz / 4) return brf_pkg::LVL_ALMOST_EMPTY;
    return brf_pkg::LVL_PARTIAL;
  endfunction

  task automatic ring_step(input brf_pkg::in_item_t it, output brf_pkg::out_item_t st);
    int unsigned sz, msk, fill, space, n, idx, cur;
    logic [BUILT_LOG2-1:0] wa;
    sz    = use_size();
    msk   = sz - 1;
    fill  = cur_fill();
    space = sz - fill;
    wa    = BUILT_LOG2'(wr_ptr & msk);
    st    = '0;
    case (it.action)
      brf_pkg::ACT_PUSH: begin
        if (fill < sz) begin
          ring_mem[wa]     = it.data;
          ring_written[wa] = 1'b1;
          wr_ptr = wr_ptr + 1'b1;
          st.done_count = 9'd1;
        end
      end
      brf_pkg::ACT_POP: begin
        if (fill > 0) begin
          st.read_data = ring_mem[ring_addr(0)];
          rd_ptr = rd_ptr + 1'b1;
          st.done_count = 9'd1;
        end
      end
      brf_pkg::ACT_PEEK: begin
        if (it.peek_offset < fill) begin
          st.read_data  = ring_mem[ring_addr(it.peek_offset)];
          st.done_count = 9'd1;
        end
      end
      brf_pkg::ACT_SKIP: begin
        n = (it.amount < fill) ? it.amount : fill;
        rd_ptr = PTR_W'(rd_ptr + n);
        st.done_count = 9'(n);
      end
      brf_pkg::ACT_COMMIT: begin
        n = (it.amount < space) ? it.amount : space;
        wr_ptr = PTR_W'(wr_ptr + n);
        st.done_count = 9'(n);
      end
      brf_pkg::ACT_DMA: begin
        idx = it.dma_index & msk;
        cur = wr_ptr & msk;
        n = (idx >= cur) ? idx - cur : idx + sz - cur;
        if (n > 0) begin
          wr_ptr = PTR_W'(wr_ptr + n);
          if (cur_fill() > sz) begin
            rd_ptr = PTR_W'(wr_ptr - sz);
            st.overrun = 1'b1;
          end
        end
        st.done_count = 9'(n);
      end
      brf_pkg::ACT_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      default: ;
    endcase
    fill = cur_fill();
    st.fill_level  = 9'(fill);
    st.free_space  = 9'(sz - fill);
    st.level_state = level_of_fill(fill, sz);
  endtask

  // random action; reads only ever land on entries a push has written
  task automatic gen_item(output brf_pkg::in_item_t it);
    int unsigned sz, fill, pick, push_w, pop_w;
    sz   = use_size();
    fill = cur_fill();
    it.data        = 8'($urandom);
    it.amount      = 9'($urandom);
    it.peek_offset = 8'($urandom);
    it.dma_index   = 8'($urandom);
    push_w = fill_bias ? 40 : 15;
    pop_w  = fill_bias ? 15 : 40;
    pick   = $urandom_range(99);
    if (pick < push_w) it.action = brf_pkg::ACT_PUSH;
    else if (pick < push_w + pop_w) it.action = brf_pkg::ACT_POP;
    else if (pick < 70) it.action = brf_pkg::ACT_PEEK;
    else if (pick < 78) it.action = brf_pkg::ACT_SKIP;
    else if (pick < 86) it.action = brf_pkg::ACT_COMMIT;
    else if (pick < 96) it.action = brf_pkg::ACT_DMA;
    else if (pick < 98) it.action = brf_pkg::ACT_CLEAR;
    else it.action = ACT_UNUSED;
    if ((it.action == brf_pkg::ACT_SKIP || it.action == brf_pkg::ACT_COMMIT) &&
        $urandom_range(99) < 80)
      it.amount = 9'($urandom_range(sz));
    if (it.action == brf_pkg::ACT_PEEK && fill > 0 && $urandom_range(99) < 75)
      it.peek_offset = 8'($urandom_range(fill - 1));
    if (it.action == brf_pkg::ACT_POP && fill > 0 && !ring_written[ring_addr(0)])
      it.action = brf_pkg::ACT_SKIP;
    if (it.action == brf_pkg::ACT_PEEK && it.peek_offset < fill &&
        !ring_written[ring_addr(it.peek_offset)]) begin
      if (fill < 256) it.peek_offset = 8'(fill);
      else it.action = brf_pkg::ACT_SKIP;
    end
  endtask

  task automatic send(input brf_pkg::in_item_t it, input logic pinned,
                      input brf_pkg::out_item_t want);
    brf_pkg::out_item_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    ring_step(it, pred);
    ring_status_q.push_back(pinned ? want : pred);
  endtask

  task automatic write_size(input logic [brf_pkg::SIZE_LOG2_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_lg = v;
    wr_ptr  = '0;
    rd_ptr  = '0;
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  function automatic brf_pkg::in_item_t act(logic [2:0] a, logic [7:0] d, logic [8:0] n,
                                            logic [7:0] o, logic [7:0] x);
    return {a, d, n, o, x};
  endfunction

  function automatic brf_pkg::out_item_t status(logic [7:0] rd, logic [8:0] dn,
                                                logic [8:0] fl, logic [8:0] fr,
                                                logic [2:0] lv, logic ov);
    return {rd, dn, fl, fr, lv, ov};
  endfunction

  function automatic dir_row_t pinned(brf_pkg::in_item_t it, brf_pkg::out_item_t st);
    return {it, 1'b1, st};
  endfunction

  function automatic dir_row_t modelled(brf_pkg::in_item_t it);
    return {it, 1'b0, NO_STATUS};
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WD_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : rx_side
    brf_pkg::out_item_t want;
    int                 hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (ring_status_q.size() == 0) begin
          $error("status transfer with nothing pending: %h", out_data);
          err_cnt++;
        end else begin
          want = ring_status_q.pop_front();
          check_field("read_data", 9'(want.read_data), 9'(out_data.read_data));
          check_field("done_count", want.done_count, out_data.done_count);
          check_field("fill_level", want.fill_level, out_data.fill_level);
          check_field("free_space", want.free_space, out_data.free_space);
          check_field("level_state", 9'(want.level_state), 9'(out_data.level_state));
          check_field("overrun", 9'(want.overrun), 9'(out_data.overrun));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : tx_side
    brf_pkg::in_item_t item;
    // reset size 256, pointers at zero
    dir_tab.push_back(pinned(act(brf_pkg::ACT_POP, 8'h00, 9'd0, 8'd0, 8'd0),
                             status(8'd0, 9'd0, 9'd0, 9'd256, brf_pkg::LVL_EMPTY, 1'b0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 8'd0, 8'd0),
                             status(8'd0, 9'd0, 9'd0, 9'd256, brf_pkg::LVL_EMPTY, 1'b0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_SKIP, 8'h00, 9'd256, 8'd0, 8'd0),
                             status(8'd0, 9'd0, 9'd0, 9'd256, brf_pkg::LVL_EMPTY, 1'b0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_PUSH, 8'hff, 9'd0, 8'd0, 8'd0),
                             status(8'd0, 9'd1, 9'd1, 9'd255,
                                    brf_pkg::LVL_ALMOST_EMPTY, 1'b0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_PUSH, 8'h00, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_PUSH, 8'ha5, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 8'd2, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 8'd255, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_POP, 8'h00, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_POP, 8'h00, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_POP, 8'h00, 9'd0, 8'd0, 8'd0)));
    // commit clamped to free space, then full
    dir_tab.push_back(pinned(act(brf_pkg::ACT_COMMIT, 8'h00, 9'd511, 8'd0, 8'd0),
                             status(8'd0, 9'd256, 9'd256, 9'd0, brf_pkg::LVL_FULL, 1'b0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_PUSH, 8'h5a, 9'd0, 8'd0, 8'd0),
                             status(8'd0, 9'd0, 9'd256, 9'd0, brf_pkg::LVL_FULL, 1'b0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_COMMIT, 8'h00, 9'd1, 8'd0, 8'd0),
                             status(8'd0, 9'd0, 9'd256, 9'd0, brf_pkg::LVL_FULL, 1'b0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_SKIP, 8'h00, 9'd255, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_PEEK, 8'h00, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_CLEAR, 8'h00, 9'd0, 8'd0, 8'd0),
                             status(8'd0, 9'd0, 9'd0, 9'd256, brf_pkg::LVL_EMPTY, 1'b0)));
    dir_tab.push_back(pinned(act(ACT_UNUSED, 8'hff, 9'd511, 8'd255, 8'd255),
                             status(8'd0, 9'd0, 9'd0, 9'd256, brf_pkg::LVL_EMPTY, 1'b0)));
    // DMA sync: plain move, wrap, overrun, no move
    dir_tab.push_back(modelled(act(brf_pkg::ACT_DMA, 8'h00, 9'd0, 8'd0, 8'd255)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_DMA, 8'h00, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(pinned(act(brf_pkg::ACT_DMA, 8'h00, 9'd0, 8'd0, 8'd3),
                             status(8'd0, 9'd3, 9'd256, 9'd0, brf_pkg::LVL_FULL, 1'b1)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_DMA, 8'h00, 9'd0, 8'd0, 8'd3)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_SKIP, 8'h00, 9'd254, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_POP, 8'h00, 9'd0, 8'd0, 8'd0)));
    dir_tab.push_back(modelled(act(brf_pkg::ACT_POP, 8'h00, 9'd0, 8'd0, 8'd0)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 14;
    rx_idle_pct = 51;
    foreach (dir_tab[i]) send(dir_tab[i].item, dir_tab[i].pinned, dir_tab[i].status);

    for (int p = 0; p < N_PHASES; p++) begin
      in_valid <= 1'b0;
      while (ring_status_q.size() != 0) @(posedge clk);
      write_size(size_plan[p]);
      if (p < 4) begin
        tx_idle_pct = 14;
        rx_idle_pct = 51;
      end else if (p < 8) begin
        tx_idle_pct = 51;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 32 == 0) fill_bias = 1'($urandom_range(1));
        gen_item(item);
        send(item, 1'b0, NO_STATUS);
      end
    end

    in_valid <= 1'b0;
    while (ring_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
